@@ rtl/sdac_pkg.sv @@
package sdac_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_TC    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PORT_MODE    = 2'd0,
    PORT_CONTROL = 2'd1,
    PORT_FREQ_LO = 2'd2,
    PORT_FREQ_HI = 2'd3
  } port_t;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_CONTROL  = 2'd1,
    MODE_RESERVED = 2'd2,
    MODE_PLAY     = 2'd3
  } mode_sel_t;

  localparam logic [7:0]  DMA_BITS_MASK  = 8'h0C;
  localparam logic [7:0]  MODE_READ_MASK = 8'h77;
  localparam logic [7:0]  MODE_IRQ_BIT   = 8'h08;
  localparam logic [7:0]  MIDSCALE       = 8'd128;
  localparam logic [7:0]  UNKNOWN_READ   = 8'hFF;
  localparam logic [11:0] FREQ_HI_MASK   = 12'hF00;
  localparam logic [11:0] FREQ_LO_MASK   = 12'h0FF;

  typedef struct packed {
    logic [7:0] dma_byte;
    logic       dma_valid;
    logic [7:0] write_data;
    port_t      port_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sample_out;
    logic [7:0] read_data;
  } out_data_t;

  typedef struct packed {
    logic irq_pulse;
    logic sample_valid;
  } out_flags_t;

  function automatic logic dma_bits_on(input logic [7:0] m);
    return (m & DMA_BITS_MASK) == DMA_BITS_MASK;
  endfunction

endpackage

@@ rtl/sound_dac_register_and_sample_unit_top.sv @@
// Sound DAC register and sample unit. Each transaction on the slave stream is
// one bus access, sample tick or DMA terminal count, selected by s_tuser, and
// gives exactly one result transaction on the master stream. The block takes
// one transaction per cycle while the master side does not stall; a result
// passes through the input and output registers before it is presented on
// the master stream; a stalled master side holds the pipeline through tready.
// The dac_present bit is written on the cfg channel and resets to 1.
module sound_dac_register_and_sample_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // port_offset[1:0], write_data[9:2], dma_valid[10], dma_byte[18:11], zero fill
  input  logic [23:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], sample_out[15:8]
  output logic [15:0] m_tdata,
  // sample_valid[0], irq_pulse[1]
  output logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import sdac_pkg::*;

  logic       in_valid;
  in_item_t   in_item;
  kind_t      in_kind;
  logic       advance;

  logic       dac_present;
  logic [7:0] mode_reg;
  logic [7:0] control_reg;
  logic [11:0] rate_divisor;
  logic [2:0] volume_level;
  logic [7:0] held_sample;
  logic       transfer_finished;

  logic [7:0]  mode_reg_next;
  logic [7:0]  control_reg_next;
  logic [11:0] rate_divisor_next;
  logic [2:0]  volume_level_next;
  logic [7:0]  held_sample_next;
  logic        transfer_finished_next;
  out_data_t   result_data;
  out_flags_t  result_flags;
  logic        playing;
  logic        mode_check;

  out_data_t   out_data;
  out_flags_t  out_flags;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign playing   = dac_present && dma_bits_on(mode_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_item <= in_item_t'(s_tdata[18:0]);
      in_kind <= kind_t'(s_tuser);
    end
  end

  always_comb begin
    mode_reg_next          = mode_reg;
    control_reg_next       = control_reg;
    rate_divisor_next      = rate_divisor;
    volume_level_next      = volume_level;
    held_sample_next       = held_sample;
    transfer_finished_next = transfer_finished;
    result_data            = '0;
    result_flags           = '0;
    mode_check             = 1'b0;
    case (in_kind)
      KIND_WRITE: begin
        case (in_item.port_offset)
          PORT_MODE: begin
            mode_reg_next = in_item.write_data;
            mode_check = (in_item.write_data[1:0] != mode_reg[1:0]) ||
                         (dma_bits_on(in_item.write_data) && !dma_bits_on(mode_reg));
            if (mode_check && mode_sel_t'(in_item.write_data[1:0]) == MODE_PLAY &&
                rate_divisor != '0 && dma_bits_on(in_item.write_data)) begin
              transfer_finished_next = 1'b0;
            end
          end
          PORT_CONTROL: begin
            if (mode_sel_t'(mode_reg[1:0]) == MODE_CONTROL) begin
              control_reg_next = in_item.write_data;
            end
          end
          PORT_FREQ_LO: begin
            rate_divisor_next = (rate_divisor & FREQ_HI_MASK) | {4'd0, in_item.write_data};
          end
          default: begin
            rate_divisor_next = (rate_divisor & FREQ_LO_MASK) |
                                {in_item.write_data[3:0], 8'd0};
            volume_level_next = in_item.write_data[7:5];
          end
        endcase
        if ((in_item.port_offset == PORT_FREQ_LO || in_item.port_offset == PORT_FREQ_HI) &&
            mode_sel_t'(mode_reg[1:0]) == MODE_PLAY && rate_divisor_next != '0 &&
            dma_bits_on(mode_reg)) begin
          transfer_finished_next = 1'b0;
        end
      end
      KIND_READ: begin
        case (in_item.port_offset)
          PORT_MODE:    result_data.read_data = mode_reg & MODE_READ_MASK & ~MODE_IRQ_BIT;
          PORT_FREQ_LO: result_data.read_data = rate_divisor[7:0];
          PORT_FREQ_HI: result_data.read_data = {volume_level, 1'b0, rate_divisor[11:8]};
          default:      result_data.read_data = UNKNOWN_READ;
        endcase
      end
      KIND_TICK: begin
        result_flags.sample_valid = 1'b1;
        if (playing) begin
          if (!transfer_finished && in_item.dma_valid) begin
            held_sample_next = in_item.dma_byte;
          end
          result_data.sample_out = held_sample_next;
        end else begin
          result_data.sample_out = held_sample;
          if (held_sample > MIDSCALE) begin
            held_sample_next = held_sample - 8'd1;
          end else if (held_sample < MIDSCALE) begin
            held_sample_next = held_sample + 8'd1;
          end
        end
      end
      default: begin
        transfer_finished_next = 1'b1;
        result_flags.irq_pulse = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dac_present       <= 1'b1;
      mode_reg          <= '0;
      control_reg       <= '0;
      rate_divisor      <= '0;
      volume_level      <= '0;
      held_sample       <= MIDSCALE;
      transfer_finished <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dac_present <= cfg_data;
      end
      if (advance) begin
        mode_reg          <= mode_reg_next;
        control_reg       <= control_reg_next;
        rate_divisor      <= rate_divisor_next;
        volume_level      <= volume_level_next;
        held_sample       <= held_sample_next;
        transfer_finished <= transfer_finished_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      out_data  <= result_data;
      out_flags <= result_flags;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_flags;

  property p_tc_sets_finished;
    @(posedge clk) disable iff (rst)
      advance && in_kind == KIND_TC |=> transfer_finished && m_tvalid && m_tuser[1];
  endproperty
  a_tc_sets_finished: assert property (p_tc_sets_finished)
    else $error("Terminal count did not set transfer_finished with an irq result.");

  property p_one_flag;
    @(posedge clk) disable iff (rst)
      m_tvalid |-> !(m_tuser[0] && m_tuser[1]);
  endproperty
  a_one_flag: assert property (p_one_flag)
    else $error("Result carries both sample and irq flags.");

  property p_sample_zero;
    @(posedge clk) disable iff (rst)
      m_tvalid && !m_tuser[0] |-> m_tdata[15:8] == 8'd0;
  endproperty
  a_sample_zero: assert property (p_sample_zero)
    else $error("Nonzero sample on a result that is not a tick.");

  property p_decay;
    @(posedge clk) disable iff (rst)
      advance && in_kind == KIND_TICK && !playing && held_sample > MIDSCALE
      |=> held_sample == 8'($past(held_sample) - 8'd1);
  endproperty
  a_decay: assert property (p_decay)
    else $error("Held sample did not step down toward midscale.");

endmodule

@@ verif/tb_sound_dac_register_and_sample_unit_top.sv @@
module tb_sound_dac_register_and_sample_unit_top;
  import sdac_pkg::*;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] smp;
    logic       sv;
    logic       irq;
  } dac_result_t;

  typedef struct {
    kind_t       kind;
    port_t       port;
    logic [7:0]  wd;
    logic        dv;
    logic [7:0]  db;
    bit          typed;
    dac_result_t want;
  } dac_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  logic        dac_on;
  logic [7:0]  mode_q;
  logic [7:0]  ctrl_q;
  logic [11:0] div_q;
  logic [2:0]  vol_q;
  logic [7:0]  held_q;
  logic        done_q;

  dac_result_t pending_results [$];
  dac_row_t    dir_rows [28];
  logic        cfg_plan [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  int items_sent   = 0;
  int results_seen = 0;
  int ticks_seen   = 0;
  int irqs_seen    = 0;
  int fails        = 0;
  int stall_left   = 0;
  bit stall_done   = 1'b0;

  sound_dac_register_and_sample_unit_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit calm();
    return items_sent >= 900 && items_sent < 1200;
  endfunction

  function automatic bit dma_enabled(input logic [7:0] m);
    return m[3] && m[2];
  endfunction

  function automatic void try_arm();
    if (mode_q[1:0] == MODE_PLAY && div_q != 12'd0 && dma_enabled(mode_q)) done_q = 1'b0;
  endfunction

  function automatic dac_result_t next_dac_result(input kind_t k, input in_item_t it);
    dac_result_t r;
    logic [7:0] prev;
    r = '0;
    case (k)
      KIND_WRITE: begin
        case (it.port_offset)
          PORT_MODE: begin
            prev = mode_q;
            mode_q = it.write_data;
            if (it.write_data[1:0] != prev[1:0]) try_arm();
            if (dma_enabled(it.write_data) && !dma_enabled(prev)) try_arm();
          end
          PORT_CONTROL: begin
            if (mode_q[1:0] == MODE_CONTROL) ctrl_q = it.write_data;
          end
          PORT_FREQ_LO: begin
            div_q[7:0] = it.write_data;
            if (mode_q[1:0] != MODE_OFF) try_arm();
          end
          default: begin
            div_q[11:8] = it.write_data[3:0];
            vol_q = it.write_data[7:5];
            if (mode_q[1:0] != MODE_OFF) try_arm();
          end
        endcase
      end
      KIND_READ: begin
        case (it.port_offset)
          PORT_MODE:    r.rd = mode_q & MODE_READ_MASK;
          PORT_FREQ_LO: r.rd = div_q[7:0];
          PORT_FREQ_HI: r.rd = {vol_q, 1'b0, div_q[11:8]};
          default:      r.rd = UNKNOWN_READ;
        endcase
      end
      KIND_TICK: begin
        r.sv = 1'b1;
        if (dac_on && dma_enabled(mode_q)) begin
          if (!done_q && it.dma_valid) held_q = it.dma_byte;
          r.smp = held_q;
        end else begin
          r.smp = held_q;
          if (held_q > MIDSCALE) held_q = held_q - 8'd1;
          else if (held_q < MIDSCALE) held_q = held_q + 8'd1;
        end
      end
      default: begin
        done_q = 1'b1;
        r.irq = 1'b1;
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input kind_t k, input port_t p, input logic [7:0] wd,
                           input logic dv, input logic [7:0] db,
                           input bit typed, input dac_result_t want);
    in_item_t it;
    dac_result_t r;
    it.port_offset = p;
    it.write_data  = wd;
    it.dma_valid   = dv;
    it.dma_byte    = db;
    while (!calm() && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {5'b0, it};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = next_dac_result(k, it);
    pending_results.push_back(typed ? want : r);
    items_sent++;
    if (k == KIND_TICK) ticks_seen++;
    if (k == KIND_TC) irqs_seen++;
  endtask

  task automatic send_random(input kind_t k, input port_t p);
    send_item(k, p, 8'($urandom), 1'($urandom_range(0, 7) != 0), 8'($urandom), 1'b0, '0);
  endtask

  task automatic set_dac_present(input logic v);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dac_on = v;
    cfg_valid <= 1'b0;
  endtask

  // A playback sequence: program the divisor, enter DMA play mode, stream
  // ticks with occasional terminal counts and reads, then leave or re-arm.
  task automatic play_burst();
    logic [7:0] m;
    send_random(KIND_WRITE, PORT_FREQ_LO);
    if ($urandom_range(0, 3) == 0) send_random(KIND_WRITE, PORT_FREQ_HI);
    m = {4'($urandom), 4'hF};
    if ($urandom_range(0, 7) == 0) m[1:0] = 2'($urandom);
    send_item(KIND_WRITE, PORT_MODE, m, 1'b0, 8'h00, 1'b0, '0);
    repeat ($urandom_range(4, 30)) begin
      case ($urandom_range(0, 19))
        0:       send_random(KIND_TC, port_t'($urandom_range(0, 3)));
        1:       send_random(KIND_READ, port_t'($urandom_range(0, 3)));
        default: send_random(KIND_TICK, port_t'($urandom_range(0, 3)));
      endcase
    end
    case ($urandom_range(0, 2))
      0: send_item(KIND_WRITE, PORT_MODE, 8'($urandom) & 8'hFC, 1'b0, 8'h00, 1'b0, '0);
      1: begin
        send_item(KIND_WRITE, PORT_MODE, {6'($urandom), MODE_CONTROL}, 1'b0, 8'h00,
                  1'b0, '0);
        send_random(KIND_WRITE, PORT_CONTROL);
      end
      default: send_random(KIND_WRITE, PORT_FREQ_LO);
    endcase
    repeat ($urandom_range(0, 12)) send_random(KIND_TICK, PORT_MODE);
  endtask

  task automatic check_result();
    dac_result_t want;
    out_data_t d;
    out_flags_t f;
    d = m_tdata;
    f = m_tuser;
    results_seen++;
    if (pending_results.size() == 0) begin
      $error("Unexpected result transaction: read_data %02h sample_out %02h", d.read_data,
             d.sample_out);
      fails++;
    end else begin
      want = pending_results.pop_front();
      if (d.read_data !== want.rd) begin
        $error("read_data: expected %02h, got %02h", want.rd, d.read_data);
        fails++;
      end
      if (d.sample_out !== want.smp) begin
        $error("sample_out: expected %02h, got %02h", want.smp, d.sample_out);
        fails++;
      end
      if (f.sample_valid !== want.sv) begin
        $error("sample_valid: expected %0b, got %0b", want.sv, f.sample_valid);
        fails++;
      end
      if (f.irq_pulse !== want.irq) begin
        $error("irq_pulse: expected %0b, got %0b", want.irq, f.irq_pulse);
        fails++;
      end
    end
  endtask

  // The receiver holds off once for a long stretch so that the pipeline fills.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!stall_done && items_sent >= 300) begin
      stall_done <= 1'b1;
      stall_left <= 80;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm() || ($urandom_range(0, 99) >= 8);
    end
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int target;
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    dac_on = 1'b1;
    mode_q = '0;
    ctrl_q = '0;
    div_q = '0;
    vol_q = '0;
    held_q = MIDSCALE;
    done_q = 1'b0;
    dir_rows = '{
      '{KIND_READ,  PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0, 1'b0}},
      '{KIND_READ,  PORT_CONTROL, 8'h00, 1'b0, 8'h00, 1'b1, {8'hFF, 8'h00, 1'b0, 1'b0}},
      '{KIND_READ,  PORT_FREQ_LO, 8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0, 1'b0}},
      '{KIND_READ,  PORT_FREQ_HI, 8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0, 1'b0}},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b1, 8'h55, 1'b1, {8'h00, 8'h80, 1'b1, 1'b0}},
      '{KIND_TC,    PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0, 1'b1}},
      '{KIND_WRITE, PORT_FREQ_LO, 8'hFF, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_WRITE, PORT_FREQ_HI, 8'hFF, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_READ,  PORT_FREQ_HI, 8'h00, 1'b0, 8'h00, 1'b1, {8'hEF, 8'h00, 1'b0, 1'b0}},
      '{KIND_WRITE, PORT_MODE,    8'h01, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_WRITE, PORT_CONTROL, 8'hAA, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_READ,  PORT_CONTROL, 8'h00, 1'b0, 8'h00, 1'b1, {8'hFF, 8'h00, 1'b0, 1'b0}},
      '{KIND_WRITE, PORT_MODE,    8'hFF, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_READ,  PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b1, {8'h77, 8'h00, 1'b0, 1'b0}},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b1, 8'h00, 1'b0, '0},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b1, 8'hFF, 1'b0, '0},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b0, 8'h12, 1'b0, '0},
      '{KIND_TC,    PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0, 1'b1}},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b1, 8'h10, 1'b0, '0},
      '{KIND_WRITE, PORT_FREQ_LO, 8'h00, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b1, 8'h00, 1'b0, '0},
      '{KIND_WRITE, PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_WRITE, PORT_FREQ_HI, 8'h00, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_TC,    PORT_MODE,    8'h00, 1'b0, 8'h00, 1'b1, {8'h00, 8'h00, 1'b0, 1'b1}},
      '{KIND_WRITE, PORT_MODE,    8'h0F, 1'b0, 8'h00, 1'b0, '0},
      '{KIND_TICK,  PORT_MODE,    8'h00, 1'b1, 8'h33, 1'b0, '0}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (cfg_plan[ph]) begin
      set_dac_present(cfg_plan[ph]);
      if (ph == 0) begin
        foreach (dir_rows[i])
          send_item(dir_rows[i].kind, dir_rows[i].port, dir_rows[i].wd, dir_rows[i].dv,
                    dir_rows[i].db, dir_rows[i].typed, dir_rows[i].want);
      end
      target = items_sent + 390;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 6) begin
          play_burst();
        end else begin
          repeat ($urandom_range(1, 6))
            send_random(kind_t'($urandom_range(0, 3)), port_t'($urandom_range(0, 3)));
        end
      end
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d transactions across %0d dac_present settings: %0d ticks, %0d TCs.",
             items_sent, $size(cfg_plan), ticks_seen, irqs_seen);
    $display("Compared %0d result transactions, %0d field mismatches.", results_seen, fails);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sdac_pkg.sv
rtl/sound_dac_register_and_sample_unit_top.sv
verif/tb_sound_dac_register_and_sample_unit_top.sv
